// ===== hdl/imm_pkg.sv =====
// Package for the integer matrix multiply core: command codes, register
// indexes, word structs and fixed field widths. No dependencies.

package imm_pkg;

	localparam int IDX_W      = 4;   // row and column fields of a word
	localparam int IN_VAL_W   = 16;  // element value field
	localparam int ACC_W      = 36;  // product value field
	localparam int CFG_W      = 5;   // dimension registers
	localparam int CFG_IDX_W  = 2;
	localparam int RESULT_CAP = 16;  // most results one compute returns

	typedef enum logic [1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		cmd_t                        command;
		logic [IDX_W-1:0]            row_index;
		logic [IDX_W-1:0]            col_index;
		logic signed [IN_VAL_W-1:0]  element_value;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]            product_col;
		logic signed [ACC_W-1:0]     product_value;
		logic                        last_in_row;
	} out_word_t;

	// control that travels down the cell chain with each A element
	typedef struct packed {
		logic valid;
		logic last;
	} chain_ctl_t;

endpackage

// ===== hdl/integer_matrix_multiply_core.sv =====
// Integer matrix multiply core. A load does not set busy. A compute keeps busy
// high until the last cell of the chain is done (NCELL = min(MAX_DIM, 16), one
// cell per B column): the A row streams down the cell chain one element per
// cycle, and the columns come out in column order, one per cycle. Reset (arst_n,
// async) clears control and loads rows_a, inner_dim and cols_b with 16; stores
// hold whatever was last written.
module integer_matrix_multiply_core #(
	parameter int MAX_DIM    = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  imm_pkg::in_word_t            item,
	output logic                         result_valid,
	output imm_pkg::out_word_t           result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  imm_pkg::reg_idx_t            cfg_index,
	input  logic [imm_pkg::CFG_W-1:0]    cfg_data
);

	import imm_pkg::*;

	localparam int EW    = ELEM_WIDTH;
	localparam int IDXW  = $clog2(MAX_DIM);
	localparam int CW    = $clog2(MAX_DIM + 1);
	localparam int NCELL = (MAX_DIM < RESULT_CAP) ? MAX_DIM : RESULT_CAP;

	function automatic logic [CW-1:0] eff(input logic [CFG_W-1:0] r, input int cap);
		if (r == '0) begin
			return CW'(1);
		end else if (int'(r) > cap) begin
			return CW'(cap);
		end
		return CW'(r);
	endfunction

	logic [CFG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic [CW-1:0]    nr, nk, nc, nk_m1;

	logic                 accept;
	logic                 in_store;
	logic                 a_we, b_load, compute_go;
	logic [IDXW-1:0]      row_w, col_w;
	logic [EW-1:0]        elem_w;

	logic                 busy_q;
	logic                 issuing_q;
	logic [IDXW-1:0]      k_q, row_q;
	logic [IDXW-1:0]      k_last;
	logic                 issue_s1, last_s1;
	logic [IDXW-1:0]      k_s1;
	logic [EW-1:0]        a_rd;

	chain_ctl_t              ctl_c [NCELL+1];
	logic [IDXW-1:0]         k_c   [NCELL+1];
	logic signed [EW-1:0]    a_c   [NCELL+1];
	logic [NCELL-1:0]        done_c;
	logic signed [ACC_W-1:0] acc_c [NCELL];

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= CFG_W'(16);
			inner_dim_q <= CFG_W'(16);
			cols_b_q    <= CFG_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign nr     = eff(rows_a_q, MAX_DIM);
	assign nk     = eff(inner_dim_q, MAX_DIM);
	assign nc     = eff(cols_b_q, NCELL);
	assign nk_m1  = nk - CW'(1);
	assign k_last = IDXW'(nk_m1);

	// command decode
	assign accept   = start & ~busy_q;
	assign in_store = (int'(item.row_index) < MAX_DIM) && (int'(item.col_index) < MAX_DIM);
	assign row_w    = IDXW'(item.row_index);
	assign col_w    = IDXW'(item.col_index);
	assign elem_w   = EW'(item.element_value);

	always_comb begin
		a_we       = 1'b0;
		b_load     = 1'b0;
		compute_go = 1'b0;
		unique case (item.command)
			CMD_LOAD_A:  a_we       = accept & in_store;
			CMD_LOAD_B:  b_load     = accept & in_store;
			CMD_COMPUTE: compute_go = accept && (int'(item.row_index) < int'(nr));
			default: ;
		endcase
	end

	// A store, addressed {row, col}
	imm_ram #(
		.WIDTH(EW),
		.DEPTH(1 << (2 * IDXW))
	) u_a_ram (
		.clk  (clk),
		.we   (a_we),
		.waddr({row_w, col_w}),
		.wdata(elem_w),
		.raddr({row_q, k_q}),
		.rdata(a_rd)
	);

	// sequencer: walks k across the selected A row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			issuing_q <= 1'b0;
			issue_s1  <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			if (compute_go) begin
				busy_q <= 1'b1;
			end else if (done_c[NCELL-1]) begin
				// whole chain drained
				busy_q <= 1'b0;
			end
			if (compute_go) begin
				issuing_q <= 1'b1;
			end else if (issuing_q && k_q == k_last) begin
				issuing_q <= 1'b0;
			end
			issue_s1 <= issuing_q;
			last_s1  <= issuing_q && (k_q == k_last);
		end
	end

	always_ff @(posedge clk) begin
		if (compute_go) begin
			k_q   <= '0;
			row_q <= row_w;
		end else if (issuing_q) begin
			k_q <= k_q + IDXW'(1);
		end
		k_s1 <= k_q;
	end

	assign busy = busy_q;

	// cell chain
	assign ctl_c[0].valid = issue_s1;
	assign ctl_c[0].last  = last_s1;
	assign k_c[0]         = k_s1;
	assign a_c[0]         = signed'(a_rd);

	for (genvar j = 0; j < NCELL; j++) begin : g_cell
		imm_cell #(
			.EW  (EW),
			.IDXW(IDXW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clear  (compute_go),
			.in_ctl (ctl_c[j]),
			.in_k   (k_c[j]),
			.in_a   (a_c[j]),
			.b_we   (b_load && (int'(item.col_index) == j)),
			.b_waddr(row_w),
			.b_wdata(elem_w),
			.out_ctl(ctl_c[j+1]),
			.out_k  (k_c[j+1]),
			.out_a  (a_c[j+1]),
			.done   (done_c[j]),
			.acc    (acc_c[j])
		);
	end

	// cells finish one per cycle in column order; at most one done at a time
	always_comb begin
		result_valid = 1'b0;
		result       = '0;
		for (int j = 0; j < NCELL; j++) begin
			if (done_c[j] && (j < int'(nc))) begin
				result_valid         = 1'b1;
				result.product_col   = IDX_W'(j);
				result.product_value = acc_c[j];
				result.last_in_row   = (j == int'(nk_m1 - nk_m1 + nc) - 1);
			end
		end
	end

endmodule

// ===== hdl/imm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency.

module imm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/imm_cell.sv =====
// One column cell of the multiply chain: owns one column of B in a local RAM,
// takes A elements from its left neighbor, accumulates the dot product.
// Depends on imm_pkg and imm_ram.

module imm_cell #(
	parameter int EW   = 16,
	parameter int IDXW = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  imm_pkg::chain_ctl_t           in_ctl,
	input  logic [IDXW-1:0]               in_k,
	input  logic signed [EW-1:0]          in_a,
	input  logic                          b_we,
	input  logic [IDXW-1:0]               b_waddr,
	input  logic [EW-1:0]                 b_wdata,
	output imm_pkg::chain_ctl_t           out_ctl,
	output logic [IDXW-1:0]               out_k,
	output logic signed [EW-1:0]          out_a,
	output logic                          done,
	output logic signed [imm_pkg::ACC_W-1:0] acc
);

	import imm_pkg::*;

	localparam int PW = (2 * EW > ACC_W) ? 2 * EW : ACC_W;

	chain_ctl_t              ctl_q;
	logic [IDXW-1:0]         k_q;
	logic signed [EW-1:0]    a_q;
	logic [EW-1:0]           b_rd;
	logic signed [2*EW-1:0]  prod_s1;
	logic                    pv_s1;
	logic                    pl_s1;
	logic signed [PW-1:0]    prod_ext;
	logic signed [ACC_W-1:0] acc_q;
	logic                    done_q;

	// column of B, indexed by row k
	imm_ram #(
		.WIDTH(EW),
		.DEPTH(1 << IDXW)
	) u_col_ram (
		.clk  (clk),
		.we   (b_we),
		.waddr(b_waddr),
		.wdata(b_wdata),
		.raddr(in_k),
		.rdata(b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q  <= '0;
			pv_s1  <= 1'b0;
			pl_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ctl_q  <= in_ctl;
			pv_s1  <= ctl_q.valid;
			pl_s1  <= ctl_q.valid & ctl_q.last;
			done_q <= pv_s1 & pl_s1;
		end
	end

	// a_q lines up with the B word read at in_k
	always_ff @(posedge clk) begin
		k_q     <= in_k;
		a_q     <= in_a;
		prod_s1 <= a_q * signed'(b_rd);
	end

	assign prod_ext = PW'(prod_s1);

	always_ff @(posedge clk) begin
		if (clear) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + prod_ext[ACC_W-1:0];
		end
	end

	assign out_ctl = ctl_q;
	assign out_k   = k_q;
	assign out_a   = a_q;
	assign done    = done_q;
	assign acc     = acc_q;

endmodule

// ===== hdl/imm_checker.sv =====
// Port-level checks for the integer matrix multiply core, bound to the top
// level. Depends on imm_pkg.

module imm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input imm_pkg::in_word_t   item,
	input logic                result_valid,
	input imm_pkg::out_word_t  result
);

	import imm_pkg::*;

	// results only come out of a running compute
	a_result_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result word outside a compute");

	// columns of a row come out back to back
	a_next_col: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_in_row |=>
			result_valid &&
			(result.product_col == IDX_W'($past(result.product_col) + IDX_W'(1))))
		else $error("product row broken or out of order");

	// nothing follows the last column
	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_in_row |=> !result_valid)
		else $error("word after end of row");

	// a load never occupies the core
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.command == CMD_LOAD_A || item.command == CMD_LOAD_B)
			|=> !busy)
		else $error("load left the core busy");

endmodule

bind integer_matrix_multiply_core imm_checker u_imm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.item        (item),
	.result_valid(result_valid),
	.result      (result)
);
